// ===== sv/u2u_pkg.sv =====
// Shared types, constants and decode helpers for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps
`default_nettype none

package u2u_pkg;

    localparam int UNIT_W     = 21;
    localparam int SLOTS      = 3;
    localparam int JQ_DEPTH   = 2;
    localparam int JQ_PTR_W   = (JQ_DEPTH > 1) ? $clog2(JQ_DEPTH) : 1;
    localparam int JQ_CNT_W   = $clog2(JQ_DEPTH + 1);

    localparam logic [UNIT_W-1:0] REPL_UNIT  = 21'h000023;
    localparam logic [UNIT_W-1:0] SUPP_BASE  = 21'h010000;
    localparam logic [UNIT_W-1:0] HI_SURR    = 21'h00D800;
    localparam logic [UNIT_W-1:0] LO_SURR    = 21'h00DC00;

    // Sequence length codes of a lead byte.
    localparam logic [2:0] LEN_BAD = 3'd0;
    localparam logic [2:0] LEN_1   = 3'd1;
    localparam logic [2:0] LEN_2   = 3'd2;
    localparam logic [2:0] LEN_3   = 3'd3;
    localparam logic [2:0] LEN_4   = 3'd4;

    // One byte's worth of results: up to three units, last_idx is the index of the final one.
    typedef struct packed {
        logic                          stream_end;
        logic [1:0]                    last_idx;
        logic [SLOTS-1:0][UNIT_W-1:0]  slot;
    } t_job;

    // Request from the front part to the job queue.
    typedef struct packed {
        logic push;
        t_job job;
    } t_job_req;

    typedef struct packed {
        logic              pair;
        logic [UNIT_W-1:0] u0;
        logic [UNIT_W-1:0] u1;
    } t_put;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        priority if (b[7] == 1'b0)        len = LEN_1;
        else if (b[7:6] == 2'b10)         len = LEN_BAD;
        else if (b[7:5] == 3'b110)        len = LEN_2;
        else if (b[7:4] == 4'b1110)       len = LEN_3;
        else if (b[7:3] == 5'b11110)      len = LEN_4;
        else                              len = LEN_BAD;
        return len;
    endfunction

    function automatic logic [UNIT_W-1:0] lead_bits(input logic [7:0] b, input logic [2:0] len);
        logic [UNIT_W-1:0] v;
        priority if (len == LEN_1) v = {14'd0, b[6:0]};
        else if (len == LEN_2)     v = {16'd0, b[4:0]};
        else if (len == LEN_3)     v = {17'd0, b[3:0]};
        else                       v = {18'd0, b[2:0]};
        return v;
    endfunction

    // A lone byte decoded as a fresh lead with room for one byte only.
    function automatic logic [UNIT_W-1:0] single_byte(input logic [7:0] b);
        return b[7] ? REPL_UNIT : {14'd0, b[6:0]};
    endfunction

    // Maps a value to one code point or UTF-16 unit, or to a surrogate pair.
    function automatic t_put put_value(input logic mode, input logic [UNIT_W-1:0] v);
        t_put              p;
        logic [UNIT_W-1:0] u;
        u      = v - SUPP_BASE;
        p.pair = mode && (v >= SUPP_BASE);
        p.u1   = LO_SURR + {11'd0, u[9:0]};
        if (p.pair) begin
            p.u0 = HI_SURR + {10'd0, u[20:10]};
        end else if (mode) begin
            p.u0 = {5'd0, v[15:0]};
        end else begin
            p.u0 = v;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== sv/utf8_to_utf16_transcoder.sv =====
// Top level of the UTF-8 to code point / UTF-16 transcoder.
//
// Usage: UTF-8 bytes enter on the slave stream, one byte per request, with
// tlast marking the final byte of a stream. Decoded results leave on the
// master stream: tdata carries a 21-bit code point (output mode 0) or a
// UTF-16 unit (output mode 1), tlast marks the last result caused by one
// input byte, and tuser marks the final result of the whole stream.
// The output mode is written through the configuration channel, which is
// always ready; write it only while no request is in flight.
// An accepted byte's job is written into the job queue and then loaded into
// the back part's output register. A byte that completes a sequence, or an
// invalid lead, gives one result, so a steady stream moves one byte per
// cycle while the receiver is ready. A surrogate pair gives two results and
// a stream that ends inside a sequence up to three, one per ready cycle.
// A two-entry job queue separates the decoder from the output register, so
// bytes are still accepted while the receiver stalls until the queue fills.
// Reset clears the open sequence, the queue and the output stage, and sets
// the output mode to code points.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_transcoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_data,      // [0] output_mode
    // Byte input stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,       // [7:0] in_byte
    input  wire logic        i_s_tlast,       // stream_last
    // Result output stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,       // [20:0] out_unit, [23:21] zero
    output logic             o_m_tlast,       // run_last
    output logic [0:0]       o_m_tuser        // [0] stream_end
);

    logic                        r_output_mode;
    logic                        s_accept;
    logic                        q_full, q_valid, q_pop;
    u2u_pkg::t_job_req           front_req;
    u2u_pkg::t_job               q_job;
    logic [u2u_pkg::UNIT_W-1:0]  out_unit;
    logic                        out_stream_end;

    // The mode register takes any write at once.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_output_mode <= i_cfg_data[0];
        end
    end

    // A byte is taken whenever the queue has room for the job it may create.
    assign o_s_tready = !q_full;
    assign s_accept   = i_s_tvalid && o_s_tready;

    u2u_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_output_mode (r_output_mode),
        .i_accept      (s_accept),
        .i_byte        (i_s_tdata),
        .i_last        (i_s_tlast),
        .o_req         (front_req)
    );

    u2u_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (front_req),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    u2u_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (q_valid),
        .i_job        (q_job),
        .o_pop        (q_pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_unit       (out_unit),
        .o_run_last   (o_m_tlast),
        .o_stream_end (out_stream_end)
    );

    assign o_m_tdata = {3'b000, out_unit};
    assign o_m_tuser = out_stream_end;

endmodule

`default_nettype wire

// ===== sv/u2u_front.sv =====
// Front part: accepts UTF-8 bytes, tracks the open sequence and builds result jobs.
`timescale 1ns / 1ps
`default_nettype none

module u2u_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_output_mode,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_last,
    output u2u_pkg::t_job_req      o_req
);

    logic [2:0]                   r_seq_len, n_seq_len;
    logic [1:0]                   r_seen, n_seen;
    logic [u2u_pkg::UNIT_W-1:0]   r_acc, n_acc;
    logic [7:0]                   r_held [0:2];

    logic [2:0]                   len;
    logic [u2u_pkg::UNIT_W-1:0]   acc_next;
    u2u_pkg::t_put                put;
    u2u_pkg::t_job                job;
    logic                         emit;
    logic                         hold_wr;

    assign len      = u2u_pkg::lead_len(i_byte);
    assign acc_next = {r_acc[u2u_pkg::UNIT_W-7:0], i_byte[5:0]};
    assign put      = u2u_pkg::put_value(i_output_mode, acc_next);

    always_comb begin
        n_seq_len      = r_seq_len;
        n_seen         = r_seen;
        n_acc          = r_acc;
        emit           = 1'b0;
        hold_wr        = 1'b0;
        job.stream_end = i_last;
        job.last_idx   = 2'd0;
        job.slot       = '{default: u2u_pkg::REPL_UNIT};
        if (r_seq_len == u2u_pkg::LEN_BAD) begin
            priority if (len == u2u_pkg::LEN_BAD) begin
                emit = 1'b1;
            end else if (len == u2u_pkg::LEN_1) begin
                emit        = 1'b1;
                job.slot[0] = {14'd0, i_byte[6:0]};
            end else if (i_last) begin
                emit = 1'b1;
            end else begin
                n_seq_len = len;
                n_seen    = 2'd1;
                n_acc     = u2u_pkg::lead_bits(i_byte, len);
            end
        end else if ({1'b0, r_seen} + 3'd1 >= r_seq_len) begin
            // Sequence complete.
            emit         = 1'b1;
            job.slot[0]  = put.u0;
            job.slot[1]  = put.u1;
            job.last_idx = put.pair ? 2'd1 : 2'd0;
            n_seq_len    = u2u_pkg::LEN_BAD;
            n_seen       = 2'd0;
            n_acc        = '0;
        end else if (i_last) begin
            // Stream cut short: replace the lead, then re-decode the bytes after it.
            emit = 1'b1;
            if (r_seen == 2'd1) begin
                job.slot[1]  = u2u_pkg::single_byte(i_byte);
                job.last_idx = 2'd1;
            end else if (u2u_pkg::lead_len(r_held[1]) == u2u_pkg::LEN_2) begin
                job.slot[1]  = {10'd0, r_held[1][4:0], i_byte[5:0]};
                job.last_idx = 2'd1;
            end else begin
                job.slot[1]  = u2u_pkg::single_byte(r_held[1]);
                job.slot[2]  = u2u_pkg::single_byte(i_byte);
                job.last_idx = 2'd2;
            end
            n_seq_len = u2u_pkg::LEN_BAD;
            n_seen    = 2'd0;
            n_acc     = '0;
        end else begin
            hold_wr = (r_seen != 2'd3);
            n_seen  = r_seen + 2'd1;
            n_acc   = acc_next;
        end
    end

    assign o_req.push = i_accept && emit;
    assign o_req.job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len <= u2u_pkg::LEN_BAD;
            r_seen    <= 2'd0;
            r_acc     <= '0;
        end else if (i_accept) begin
            r_seq_len <= n_seq_len;
            r_seen    <= n_seen;
            r_acc     <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && (r_seq_len == u2u_pkg::LEN_BAD)) begin
            r_held[0] <= i_byte;
        end else if (i_accept && hold_wr) begin
            r_held[r_seen] <= i_byte;
        end
    end

endmodule

`default_nettype wire

// ===== sv/u2u_job_queue.sv =====
// Short job queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module u2u_job_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire u2u_pkg::t_job_req i_req,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output u2u_pkg::t_job          o_job
);

    localparam logic [u2u_pkg::JQ_PTR_W-1:0] LAST_PTR = u2u_pkg::JQ_PTR_W'(u2u_pkg::JQ_DEPTH - 1);
    localparam logic [u2u_pkg::JQ_CNT_W-1:0] FULL_CNT = u2u_pkg::JQ_CNT_W'(u2u_pkg::JQ_DEPTH);

    u2u_pkg::t_job                  r_mem [0:u2u_pkg::JQ_DEPTH-1];
    logic [u2u_pkg::JQ_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [u2u_pkg::JQ_CNT_W-1:0]   r_count;
    logic                           do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_req.push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_req.job;
        end
    end

endmodule

`default_nettype wire

// ===== sv/u2u_back.sv =====
// Back part: walks each job's units into the registered output stage.
`timescale 1ns / 1ps
`default_nettype none

module u2u_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_job_valid,
    input  wire u2u_pkg::t_job                i_job,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [u2u_pkg::UNIT_W-1:0]        o_unit,
    output logic                              o_run_last,
    output logic                              o_stream_end
);

    logic [1:0]                   r_slot;
    logic                         r_valid;
    logic [u2u_pkg::UNIT_W-1:0]   r_unit;
    logic                         r_run_last, r_stream_end;
    logic                         load, at_end;

    assign load   = i_job_valid && (!r_valid || i_ready);
    assign at_end = (r_slot == i_job.last_idx);
    assign o_pop  = load && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_slot  <= at_end ? 2'd0 : r_slot + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_unit       <= i_job.slot[r_slot];
            r_run_last   <= at_end;
            r_stream_end <= at_end && i_job.stream_end;
        end
    end

    assign o_valid      = r_valid;
    assign o_unit       = r_unit;
    assign o_run_last   = r_run_last;
    assign o_stream_end = r_stream_end;

endmodule

`default_nettype wire
